/* hdl/min_window_peak_to_peak_macros.svh */
// Assertion helpers for the peak-to-peak block.
`ifndef MIN_WINDOW_PEAK_TO_PEAK_MACROS_SVH
`define MIN_WINDOW_PEAK_TO_PEAK_MACROS_SVH

// Same-cycle implication.
`define MWP_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication.
`define MWP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/mwp_pkg.sv */
package mwp_pkg;

   localparam int MAX_WINDOW  = 64;
   localparam int SAMPLE_BITS = 32;
   localparam int FIELD_BITS  = 32;
   localparam int CFG_BITS    = 7;
   localparam int LEN_BITS    = $clog2(MAX_WINDOW + 1);
   localparam int IDX_BITS    = $clog2(MAX_WINDOW);
   localparam int WIDE_BITS   = (LEN_BITS > CFG_BITS) ? LEN_BITS : CFG_BITS;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;
   typedef logic [FIELD_BITS-1:0]         spread_type;
   typedef logic [LEN_BITS-1:0]           len_type;
   typedef logic [IDX_BITS-1:0]           idx_type;

   // Largest and smallest of the newest samples up to a cell's depth.
   typedef struct packed {
      sample_type hi;
      sample_type lo;
   } extreme_type;

   typedef struct packed {
      logic advance;  // a new word enters the chain
      logic tap;      // this cell feeds the window result
   } cell_ctl_type;

endpackage

/* hdl/mwp_channel_if.sv */
interface mwp_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] sample;
   logic        last_sample;

   modport source (output valid, output sample, output last_sample, input ready);
   modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

interface mwp_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] smallest_spread;
   logic        window_found;

   modport source (output valid, output smallest_spread, output window_found, input ready);
   modport sink   (input valid, input smallest_spread, input window_found, output ready);
endinterface

/* hdl/min_window_peak_to_peak.sv */
// Smallest peak-to-peak spread over sliding windows. One sample word is taken
// per clock while the result side is not stalled; a result word is registered
// once the sample closing its sequence leaves stage two. A chain of MAX_WINDOW
// cells keeps the running max/min of the newest 1..MAX_WINDOW samples, so
// any window length costs the same: stage one picks the cell at the window
// length, stage two subtracts and updates the best spread. csr_write_data
// sets the window length (0 acts as 1, above MAX_WINDOW acts as MAX_WINDOW)
// and should be written only while no sample is in flight.
module min_window_peak_to_peak
   import mwp_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   mwp_req_if.sink             req_chan,
   mwp_rsp_if.source           rsp_chan,
   input  logic                csr_write_enable,
   input  logic [CFG_BITS-1:0] csr_write_data
);

   logic [CFG_BITS-1:0] cfg_len_ff;
   len_type             seen_ff;
   len_type             seen_in;
   len_type             eff_len;
   logic [WIDE_BITS-1:0] cfg_wide;
   logic                win_in;
   logic                accept;
   logic                advance;
   sample_type          new_sample;

   logic                s1_valid_ff;
   logic                s1_win_ff;
   logic                s1_last_ff;
   idx_type             s1_idx_ff;

   logic                s2_valid_ff;
   logic                s2_win_ff;
   logic                s2_last_ff;
   sample_type          s2_hi_ff;
   sample_type          s2_lo_ff;

   spread_type          best_ff;
   spread_type          best_in;
   logic                any_ff;
   logic                any_in;
   spread_type          spread;
   logic [SAMPLE_BITS:0] diff;

   logic                rsp_valid_ff;
   spread_type          rsp_spread_ff;
   logic                rsp_found_ff;

   cell_ctl_type        ctl   [MAX_WINDOW];
   extreme_type         chain [MAX_WINDOW];
   extreme_type         taps  [MAX_WINDOW];
   extreme_type         prev  [MAX_WINDOW];
   extreme_type         picked;

   // The whole pipe moves only when the output register can take a word.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = advance;
   assign accept         = req_chan.valid && advance;
   assign new_sample     = sample_type'(req_chan.sample[SAMPLE_BITS-1:0]);

   assign cfg_wide = WIDE_BITS'(cfg_len_ff);

   always_comb begin
      if (cfg_wide == '0) begin
         eff_len = len_type'(1);
      end else if (cfg_wide > WIDE_BITS'(MAX_WINDOW)) begin
         eff_len = len_type'(MAX_WINDOW);
      end else begin
         eff_len = cfg_wide[LEN_BITS-1:0];
      end
   end

   // Count saturates at the current length; a shorter count regrows after a
   // length increase.
   always_comb begin
      seen_in = (seen_ff < eff_len) ? seen_ff + len_type'(1) : eff_len;
      win_in  = (seen_in == eff_len);
   end

   // Cell chain
   always_comb begin
      for (int j = 0; j < MAX_WINDOW; j++) begin
         ctl[j].advance = accept;
         ctl[j].tap     = (s1_idx_ff == idx_type'(j));
      end
      prev[0].hi = new_sample;
      prev[0].lo = new_sample;
      for (int j = 1; j < MAX_WINDOW; j++) begin
         prev[j] = chain[j-1];
      end
   end

   for (genvar g = 0; g < MAX_WINDOW; g++) begin : g_cell
      mwp_cell u_cell (
         .clock   (clock),
         .ctl     (ctl[g]),
         .sample  (new_sample),
         .prev    (prev[g]),
         .cur     (chain[g]),
         .tap_out (taps[g])
      );
   end

   // Only the tapped cell is nonzero.
   always_comb begin
      picked = '0;
      for (int j = 0; j < MAX_WINDOW; j++) begin
         picked = picked | taps[j];
      end
   end

   always_comb begin
      diff    = {s2_hi_ff[SAMPLE_BITS-1], s2_hi_ff} - {s2_lo_ff[SAMPLE_BITS-1], s2_lo_ff};
      spread  = FIELD_BITS'(diff[SAMPLE_BITS-1:0]);
      best_in = (s2_win_ff && (spread < best_ff)) ? spread : best_ff;
      any_in  = any_ff || s2_win_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_len_ff   <= CFG_BITS'(1);
         seen_ff      <= '0;
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         best_ff      <= '1;
         any_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write_enable) begin
            cfg_len_ff <= csr_write_data;
         end
         if (accept) begin
            seen_ff <= req_chan.last_sample ? '0 : seen_in;
         end
         if (advance) begin
            s1_valid_ff  <= accept;
            s2_valid_ff  <= s1_valid_ff;
            rsp_valid_ff <= s2_valid_ff && s2_last_ff;
            if (s2_valid_ff) begin
               best_ff <= s2_last_ff ? '1 : best_in;
               any_ff  <= s2_last_ff ? 1'b0 : any_in;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_win_ff  <= win_in;
         s1_last_ff <= req_chan.last_sample;
         s1_idx_ff  <= IDX_BITS'(eff_len - len_type'(1));
         s2_win_ff  <= s1_win_ff;
         s2_last_ff <= s1_last_ff;
         s2_hi_ff   <= picked.hi;
         s2_lo_ff   <= picked.lo;
         if (s2_valid_ff && s2_last_ff) begin
            rsp_spread_ff <= any_in ? best_in : '0;
            rsp_found_ff  <= any_in;
         end
      end
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.smallest_spread = rsp_spread_ff;
   assign rsp_chan.window_found    = rsp_found_ff;

`include "min_window_peak_to_peak_macros.svh"

   `MWP_ASSERT_NEXT(a_seq_restart, clock, reset, accept && req_chan.last_sample, seen_ff == '0, "count not cleared at end of sequence")
   `MWP_ASSERT_NEXT(a_seen_bound, clock, reset, accept && !req_chan.last_sample, seen_ff <= $past(eff_len), "count beyond window length")
   `MWP_ASSERT_NOW(a_empty_result, clock, reset, rsp_valid_ff && !rsp_found_ff, rsp_spread_ff == '0, "nonzero spread without window")
   `MWP_ASSERT_NEXT(a_stall_hold, clock, reset, !advance, $stable(s2_hi_ff) && $stable(best_ff), "pipe moved while stalled")

endmodule

/* hdl/mwp_cell.sv */
module mwp_cell
   import mwp_pkg::*;
(
   input  logic         clock,
   input  cell_ctl_type ctl,
   input  sample_type   sample,
   input  extreme_type  prev,
   output extreme_type  cur,
   output extreme_type  tap_out
);

   extreme_type ext_ff;
   extreme_type ext_in;

   // Depth j holds max/min of the newest j+1 samples: fold the new sample
   // into what the neighbor held for depth j-1.
   always_comb begin
      ext_in.hi = (sample > prev.hi) ? sample : prev.hi;
      ext_in.lo = (sample < prev.lo) ? sample : prev.lo;
   end

   always_ff @(posedge clock) begin
      if (ctl.advance) begin
         ext_ff <= ext_in;
      end
   end

   assign cur     = ext_ff;
   assign tap_out = ctl.tap ? ext_ff : '0;

endmodule
